>>> src/color_channel_extractor_macros.svh
// Assertion macros for the color channel extractor checker
`ifndef COLOR_CHANNEL_EXTRACTOR_MACROS_SVH
`define COLOR_CHANNEL_EXTRACTOR_MACROS_SVH

// Same-cycle implication, dropped while reset is high
`define CCE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("channel extractor assertion failed");

// Next-cycle implication, checked in reset too
`define CCE_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("channel extractor assertion failed");

`endif

>>> src/cce_pkg.sv
// Shared types and constants for the color channel extractor
`timescale 1ns / 1ps
package cce_pkg;

  localparam int COMPONENT_BITS_DEFAULT = 8;
  localparam int MODE_BITS = 4;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_RED     = 4'd0,
    MODE_GREEN   = 4'd1,
    MODE_BLUE    = 4'd2,
    MODE_CYAN    = 4'd3,
    MODE_MAGENTA = 4'd4,
    MODE_YELLOW  = 4'd5,
    MODE_LUMA    = 4'd6,
    MODE_U       = 4'd7,
    MODE_V       = 4'd8,
    MODE_HUE     = 4'd9,
    MODE_LIGHT   = 4'd10,
    MODE_SAT     = 4'd11
  } mode_t;

  typedef enum logic [1:0] {
    MAX_R = 2'd0,
    MAX_G = 2'd1,
    MAX_B = 2'd2
  } max_sel_t;

  // control bits that travel with each pixel down the chain
  typedef struct packed {
    logic valid;
    logic use_div;
  } ctl_t;

  localparam int LUMA_WR = 77;
  localparam int LUMA_WG = 150;
  localparam int LUMA_WB = 29;
  localparam int U_WEIGHT = 126;
  localparam int V_WEIGHT = 225;

endpackage

>>> src/cce_div_cell.sv
// One restoring-division cell: one quotient bit per cell
`timescale 1ns / 1ps
module cce_div_cell
  import cce_pkg::*;
#(
  parameter int W  = COMPONENT_BITS_DEFAULT,
  parameter int NW = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  ctl_t          ctl_in,
  input  logic [W-1:0]  simple_in,
  input  logic [NW-1:0] rem_in,
  input  logic [NW-1:0] dsh_in,
  input  logic [W-1:0]  q_in,
  output ctl_t          ctl_out,
  output logic [W-1:0]  simple_out,
  output logic [NW-1:0] rem_out,
  output logic [NW-1:0] dsh_out,
  output logic [W-1:0]  q_out
);

  logic ge;

  assign ge = (rem_in >= dsh_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    simple_out <= simple_in;
    rem_out    <= ge ? (rem_in - dsh_in) : rem_in;
    dsh_out    <= dsh_in >> 1;
    q_out      <= {q_in[W-2:0], ge};
  end

endmodule

>>> src/cce_front.sv
// Front stages: components, luma, chroma and divider operands
`timescale 1ns / 1ps
module cce_front
  import cce_pkg::*;
#(
  parameter int W = COMPONENT_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [W-1:0]         red,
  input  logic [W-1:0]         green,
  input  logic [W-1:0]         blue,
  input  logic [MODE_BITS-1:0] mode,
  output ctl_t                 ctl,
  output logic [W-1:0]         simple,
  output logic [W+$clog2(360*((1<<W)-1)+1)-1:0] num,
  output logic [W+$clog2(360*((1<<W)-1)+1)-1:0] dsh
);

  localparam int FULL = (1 << W) - 1;
  localparam int DW   = $clog2(360 * FULL + 1);
  localparam int NW   = DW + W;
  localparam int HW   = DW + 2;
  localparam int LW   = W + 8;
  localparam int PW   = W + 10;

  localparam logic signed [HW-1:0] K60  = HW'(60);
  localparam logic signed [HW-1:0] K120 = HW'(120);
  localparam logic signed [HW-1:0] K240 = HW'(240);
  localparam logic signed [HW-1:0] K360 = HW'(360);
  localparam logic signed [PW-1:0] KU   = PW'(U_WEIGHT);
  localparam logic signed [PW-1:0] KV   = PW'(V_WEIGHT);

  // stage A
  logic [W-1:0]        mx_c, mn_c;
  max_sel_t            sel_c;
  logic signed [W:0]   diff_c;
  logic [LW-1:0]       lsum;

  logic                a_valid;
  logic [W-1:0]        a_r, a_g, a_b, a_mx, a_mn, a_y;
  max_sel_t            a_sel;
  logic signed [W:0]   a_diff;

  always_comb begin
    if (red >= green && red >= blue) begin
      sel_c  = MAX_R;
      mx_c   = red;
      diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      sel_c  = MAX_G;
      mx_c   = green;
      diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sel_c  = MAX_B;
      mx_c   = blue;
      diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    if (red <= green && red <= blue) begin
      mn_c = red;
    end else if (green <= blue) begin
      mn_c = green;
    end else begin
      mn_c = blue;
    end
    lsum = LW'(red) * LW'(LUMA_WR) + LW'(green) * LW'(LUMA_WG)
         + LW'(blue) * LW'(LUMA_WB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= red;
    a_g    <= green;
    a_b    <= blue;
    a_mx   <= mx_c;
    a_mn   <= mn_c;
    a_sel  <= sel_c;
    a_diff <= diff_c;
    a_y    <= lsum[LW-1:8];
  end

  // stage B
  logic [W-1:0]        d;
  logic [W:0]          s;
  logic signed [HW-1:0] d_s, diff_s, n_raw, n_fix;
  logic [DW-1:0]       n_u, den_hue;
  logic [W:0]          den_sat;
  logic [NW-1:0]       num_hue, num_sat;
  logic signed [W:0]   cdiff;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]       pabs;
  logic [W-1:0]        mag, chroma;
  logic [W-1:0]        simple_next;
  logic                use_div_next;
  logic [NW-1:0]       num_next, den_next;

  always_comb begin
    d      = a_mx - a_mn;
    s      = {1'b0, a_mx} + {1'b0, a_mn};
    d_s    = $signed({{(HW-W){1'b0}}, d});
    diff_s = HW'(a_diff);
    case (a_sel)
      MAX_G:   n_raw = d_s * K120 + diff_s * K60;
      MAX_B:   n_raw = d_s * K240 + diff_s * K60;
      default: n_raw = diff_s * K60;
    endcase
    n_fix   = n_raw[HW-1] ? (n_raw + d_s * K360) : n_raw;
    n_u     = n_fix[DW-1:0];
    den_hue = DW'(d) * DW'(360);
    // x * FULL as (x << W) - x
    num_hue = {n_u, {W{1'b0}}} - NW'(n_u);
    num_sat = {DW'(d), {W{1'b0}}} - NW'(d);
    den_sat = (s <= (W+1)'(FULL)) ? s : ((W+1)'(2 * FULL) - s);

    // chroma: truncate toward zero, keep low bits
    if (mode_t'(mode) == MODE_U) begin
      cdiff = $signed({1'b0, a_b}) - $signed({1'b0, a_y});
      prod  = PW'(cdiff) * KU;
    end else begin
      cdiff = $signed({1'b0, a_r}) - $signed({1'b0, a_y});
      prod  = PW'(cdiff) * KV;
    end
    pabs   = prod[PW-1] ? (PW'(0) - $unsigned(prod)) : $unsigned(prod);
    mag    = pabs[W+7:8];
    chroma = prod[PW-1] ? (W'(0) - mag) : mag;

    use_div_next = 1'b0;
    num_next     = num_sat;
    den_next     = NW'(den_sat);
    case (mode_t'(mode))
      MODE_RED:     simple_next = a_r;
      MODE_GREEN:   simple_next = a_g;
      MODE_BLUE:    simple_next = a_b;
      MODE_CYAN:    simple_next = W'(FULL) - a_r;
      MODE_MAGENTA: simple_next = W'(FULL) - a_g;
      MODE_YELLOW:  simple_next = W'(FULL) - a_b;
      MODE_LUMA:    simple_next = a_y;
      MODE_U:       simple_next = chroma;
      MODE_V:       simple_next = chroma;
      MODE_LIGHT:   simple_next = s[W:1];
      MODE_HUE: begin
        simple_next  = '0;
        use_div_next = (d != '0);
        num_next     = num_hue;
        den_next     = NW'(den_hue);
      end
      MODE_SAT: begin
        simple_next  = '0;
        use_div_next = (d != '0);
      end
      default:      simple_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid   <= a_valid;
      ctl.use_div <= use_div_next;
    end
  end

  always_ff @(posedge clk) begin
    simple <= simple_next;
    num    <= num_next;
    dsh    <= den_next << (W - 1);
  end

endmodule

>>> src/color_channel_extractor.sv
// Top level of the color channel extractor
`timescale 1ns / 1ps
// Color channel extractor: one RGB pixel in, one channel value out.
// Input: a pixel (red_in, green_in, blue_in) is transferred at a rising edge
//   with start high and busy low. busy is low except in reset, so a pixel
//   may be taken on every clock.
// Config: channel_mode_wdata is written to the mode register at an edge with
//   channel_mode_we high. Write it only while no pixel is in flight.
// Output: done is high for one cycle with channel_value; that edge is the
//   transfer. The receiver cannot stall the block and must take it.
// Path: from the input transfer to the output transfer a pixel passes two front
//   stages, one division cell per quotient bit, and the output register. Modes
//   that need no division ride the same chain so results stay in order.
// Throughput: one pixel per clock, set by the fully pipelined cell chain.
// Reset: rst (synchronous) clears the mode register to red and drops every
//   in-flight pixel; no result is shown for pixels dropped that way.
module color_channel_extractor
  import cce_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [COMPONENT_BITS-1:0] red_in,
  input  logic [COMPONENT_BITS-1:0] green_in,
  input  logic [COMPONENT_BITS-1:0] blue_in,
  input  logic                      channel_mode_we,
  input  logic [MODE_BITS-1:0]      channel_mode_wdata,
  output logic                      done,
  output logic [COMPONENT_BITS-1:0] channel_value
);

  localparam int W    = COMPONENT_BITS;
  localparam int FULL = (1 << W) - 1;
  localparam int DW   = $clog2(360 * FULL + 1);
  localparam int NW   = DW + W;

  logic [MODE_BITS-1:0] channel_mode;

  ctl_t          ctl_c   [W+1];
  logic [W-1:0]  simple_c[W+1];
  logic [NW-1:0] rem_c   [W+1];
  logic [NW-1:0] dsh_c   [W+1];
  logic [W-1:0]  q_c     [W+1];

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mode <= MODE_RED;
    end else if (channel_mode_we) begin
      channel_mode <= channel_mode_wdata;
    end
  end

  cce_front #(.W(W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .red      (red_in),
    .green    (green_in),
    .blue     (blue_in),
    .mode     (channel_mode),
    .ctl      (ctl_c[0]),
    .simple   (simple_c[0]),
    .num      (rem_c[0]),
    .dsh      (dsh_c[0])
  );

  assign q_c[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_cell
    cce_div_cell #(.W(W), .NW(NW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl_in     (ctl_c[i]),
      .simple_in  (simple_c[i]),
      .rem_in     (rem_c[i]),
      .dsh_in     (dsh_c[i]),
      .q_in       (q_c[i]),
      .ctl_out    (ctl_c[i+1]),
      .simple_out (simple_c[i+1]),
      .rem_out    (rem_c[i+1]),
      .dsh_out    (dsh_c[i+1]),
      .q_out      (q_c[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_c[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    channel_value <= ctl_c[W].use_div ? q_c[W] : simple_c[W];
  end

endmodule

>>> src/cce_checker.sv
// Port-level assertions for the color channel extractor, with bind
`timescale 1ns / 1ps
`include "color_channel_extractor_macros.svh"
module cce_checker
  import cce_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEFAULT
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic [COMPONENT_BITS-1:0] red_in,
  input logic [MODE_BITS-1:0]      channel_mode,
  input logic                      done,
  input logic [COMPONENT_BITS-1:0] channel_value
);

  localparam int LAT = COMPONENT_BITS + 3;

  logic acc;
  assign acc = start && !busy;

  `CCE_ASSERT_IMP(a_done_has_source, clk, rst, done, $past(acc, LAT))
  `CCE_ASSERT_IMP(a_red_passthrough, clk, rst, done && channel_mode == MODE_RED && $past(channel_mode == MODE_RED, LAT), channel_value == $past(red_in, LAT))
  `CCE_ASSERT_NEXT(a_reset_clears, clk, rst, !done)
  `CCE_ASSERT_IMP(a_no_done_from_idle, clk, rst, !$past(acc, LAT), !done)

endmodule

bind color_channel_extractor cce_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_cce_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .red_in        (red_in),
  .channel_mode  (channel_mode),
  .done          (done),
  .channel_value (channel_value)
);

>>> dv/color_channel_extractor_test.sv
// Testbench for the color channel extractor: random and directed pixels, all modes
`timescale 1ns / 1ps
module color_channel_extractor_test;
  import cce_pkg::*;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
  logic channel_mode_we = 1'b0;
  logic [MODE_BITS-1:0] channel_mode_wdata = '0;
  logic done;
  logic [7:0] channel_value;

  color_channel_extractor dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .channel_mode_we(channel_mode_we), .channel_mode_wdata(channel_mode_wdata),
    .done(done), .channel_value(channel_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pixel_t pending_pixels[$];
  logic [7:0] expected_values[$];
  logic [MODE_BITS-1:0] cur_mode;
  int unsigned gap_pct;
  bit hold_off;
  int error_count;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic logic [7:0] chroma(input int weight, input int diff);
    int p;
    int mag;
    p = weight * diff;
    mag = (p < 0 ? -p : p) >>> 8;
    return (p < 0) ? 8'(-mag) : 8'(mag);
  endfunction

  function automatic logic [7:0] extract_channel(input logic [3:0] mode, input pixel_t px);
    int r, g, b, mx, mn, y, d, s, n;
    longint q;
    r = px.r; g = px.g; b = px.b;
    mx = r > g ? r : g;
    mn = r < g ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    y = (LUMA_WR * r + LUMA_WG * g + LUMA_WB * b) >> 8;
    d = mx - mn;
    s = mx + mn;
    case (mode)
      MODE_RED: return 8'(r);
      MODE_GREEN: return 8'(g);
      MODE_BLUE: return 8'(b);
      MODE_CYAN: return 8'(255 - r);
      MODE_MAGENTA: return 8'(255 - g);
      MODE_YELLOW: return 8'(255 - b);
      MODE_LUMA: return 8'(y);
      MODE_U: return chroma(U_WEIGHT, b - y);
      MODE_V: return chroma(V_WEIGHT, r - y);
      MODE_HUE: begin
        if (d == 0) return 8'd0;
        if (mx == r) n = 60 * (g - b);
        else if (mx == g) n = 120 * d + 60 * (b - r);
        else n = 240 * d + 60 * (r - g);
        if (n < 0) n += 360 * d;
        q = (longint'(n) * 255) / (360 * d);
        return 8'(q);
      end
      MODE_LIGHT: return 8'(s >> 1);
      MODE_SAT: begin
        if (d == 0) return 8'd0;
        q = (longint'(d) * 255) / (s <= 255 ? s : 510 - s);
        return 8'(q);
      end
      default: return 8'd0;
    endcase
  endfunction

  // driver: one transfer per edge with start high and busy low
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_values.push_back(extract_channel(cur_mode, {red_in, green_in, blue_in}));
      end
      if (!(start && busy)) begin
        if (!hold_off && pending_pixels.size() > 0 && $urandom_range(99) >= gap_pct) begin
          pixel_t px;
          px = pending_pixels.pop_front();
          start <= 1'b1;
          red_in <= px.r; green_in <= px.g; blue_in <= px.b;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_values.size() == 0) begin
        report($sformatf("unexpected result %0d", channel_value));
      end else begin
        logic [7:0] want;
        want = expected_values.pop_front();
        if (channel_value !== want)
          report($sformatf("mode %0d got %0d want %0d", cur_mode, channel_value, want));
      end
    end
  end

  task automatic drain();
    while (pending_pixels.size() > 0 || start || expected_values.size() > 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_mode(input logic [3:0] mode);
    drain();
    channel_mode_wdata <= mode;
    channel_mode_we <= 1'b1;
    @(posedge clk);
    channel_mode_we <= 1'b0;
    cur_mode = mode;
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t px;
    int kind;
    kind = $urandom_range(9);
    px = 24'($urandom);
    if (kind == 0) begin
      px.g = px.r; px.b = px.r;
    end else if (kind == 1) begin
      px.g = px.r;
    end else if (kind == 2) begin
      px.b = ($urandom_range(1)) ? px.r : px.g;
    end
    return px;
  endfunction

  initial begin
    error_count = 0;
    cur_mode = MODE_RED;
    gap_pct = 7;
    hold_off = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, grays and ties under every mode
    for (int m = 0; m < 16; m++) begin
      set_mode(4'(m));
      pending_pixels.push_back({8'd0, 8'd0, 8'd0});
      pending_pixels.push_back({8'd255, 8'd255, 8'd255});
      pending_pixels.push_back({8'd255, 8'd0, 8'd0});
      pending_pixels.push_back({8'd0, 8'd255, 8'd0});
      pending_pixels.push_back({8'd0, 8'd0, 8'd255});
      pending_pixels.push_back({8'd255, 8'd255, 8'd0});
      pending_pixels.push_back({8'd0, 8'd255, 8'd255});
      pending_pixels.push_back({8'd128, 8'd128, 8'd128});
      pending_pixels.push_back({8'd200, 8'd100, 8'd200});
      pending_pixels.push_back({8'd255, 8'd1, 8'd254});
      pending_pixels.push_back({8'd170, 8'd85, 8'd0});
      pending_pixels.push_back({8'd0, 8'd0, 8'd1});
    end
    // hold the sender until everything has come back
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 7 : (phase == 1) ? 85 : 0;
      for (int k = 0; k < 6; k++) begin
        set_mode(k == 0 ? MODE_SAT : k == 1 ? MODE_RED : 4'($urandom_range(15)));
        for (int i = 0; i < 44; i++) pending_pixels.push_back(rand_pixel());
        if (k == 3) begin
          drain();
          hold_off = 1'b1;
          for (int i = 0; i < 8; i++) pending_pixels.push_back(rand_pixel());
          while (expected_values.size() > 0 || start) @(posedge clk);
          hold_off = 1'b0;
        end
      end
    end
    drain();
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
